FILE: rtl/cdq_pkg.sv
// Shared constants, request codes and controller/datapath signal types for the deque.
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int FUNC_W        = 3;
  localparam int WORD_W        = 32;
  localparam int COUNT_OUT_W   = 11;

  // Request codes; codes five to seven act as query only
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request beat
    logic exec;     // apply the operation and latch the result flags
    op_t  op;       // operation to apply during exec
    logic perr;     // pop found the queue empty
    logic drop;     // push refused, queue full
    logic read;     // fetch front and back words at the new pointers
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [FUNC_W-1:0] func;
  } stat_t;

endpackage

FILE: rtl/cdq_if.sv
// Request and response channel interfaces of the deque.
interface cdq_req_if;
  logic                                valid;
  logic                                ready;
  logic        [cdq_pkg::FUNC_W-1:0]   func;
  logic signed [cdq_pkg::WORD_W-1:0]   push_word;

  modport source (output valid, output func, output push_word, input ready);
  modport sink   (input valid, input func, input push_word, output ready);
endinterface

interface cdq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cdq_pkg::WORD_W-1:0]     popped_word;
  logic                                  pop_error;
  logic                                  push_dropped;
  logic        [cdq_pkg::COUNT_OUT_W-1:0] entry_count;
  logic                                  is_empty;
  logic signed [cdq_pkg::WORD_W-1:0]     front_word;
  logic signed [cdq_pkg::WORD_W-1:0]     back_word;

  modport source (output valid, output popped_word, output pop_error, output push_dropped,
                  output entry_count, output is_empty, output front_word, output back_word,
                  input ready);
  modport sink   (input valid, input popped_word, input pop_error, input push_dropped,
                  input entry_count, input is_empty, input front_word, input back_word,
                  output ready);
endinterface

FILE: rtl/circular_deque.sv
// Circular deque top level: one request beat in, one response beat out.
// After a request beat is accepted, the controller passes through S_EXEC and S_READ
// and then raises the registered response valid in S_OUT.
// A new request is taken only after the response beat has been taken; the store
// write, then the two-port read of the new front and back words, lies in between.
// Reset (synchronous, active high): head, tail and count go to zero; the word store
// is not cleared and needs no clearing pass, so requests are taken right after reset.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  cdq_pkg::cmd_t  cmd;
  cdq_pkg::stat_t stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (req.func),
    .push_word    (req.push_word),
    .popped_word  (rsp.popped_word),
    .pop_error    (rsp.pop_error),
    .push_dropped (rsp.push_dropped),
    .entry_count  (rsp.entry_count),
    .is_empty     (rsp.is_empty),
    .front_word   (rsp.front_word),
    .back_word    (rsp.back_word)
  );

`ifndef SYNTH
  // One request in flight: never ready for a new beat while a response waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted while response pending");

  // Response taken returns the block to accepting requests
  a_ready_after_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready) |=> req.ready)
    else $error("not ready after response beat");

  // A failed pop leaves the queue empty
  a_perr_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.pop_error) |-> rsp.is_empty)
    else $error("pop error with non-empty queue");

  // A dropped push means the queue was full, so not empty
  a_drop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.push_dropped) |-> !rsp.is_empty)
    else $error("push dropped on empty queue");
`endif

endmodule

FILE: rtl/cdq_ctrl.sv
// Deque controller: request sequencing, operation decode and handshakes.
module cdq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cdq_pkg::stat_t  stat,
  output cdq_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_t;

  state_t state;

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          state <= S_READ;
        end
        S_READ: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // Decode the latched request against full/empty
  always_comb begin
    cmd         = '0;
    cmd.op      = cdq_pkg::OP_NONE;
    cmd.capture = in_valid && in_ready;
    cmd.exec    = (state == S_EXEC);
    cmd.read    = (state == S_READ);
    if (state == S_EXEC) begin
      case (stat.func)
        cdq_pkg::FUNC_PUSH_FRONT: begin
          if (stat.full) cmd.drop = 1'b1;
          else           cmd.op   = cdq_pkg::OP_PUSH_FRONT;
        end
        cdq_pkg::FUNC_PUSH_BACK: begin
          if (stat.full) cmd.drop = 1'b1;
          else           cmd.op   = cdq_pkg::OP_PUSH_BACK;
        end
        cdq_pkg::FUNC_POP_FRONT: begin
          if (stat.empty) cmd.perr = 1'b1;
          else            cmd.op   = cdq_pkg::OP_POP_FRONT;
        end
        cdq_pkg::FUNC_POP_BACK: begin
          if (stat.empty) cmd.perr = 1'b1;
          else            cmd.op   = cdq_pkg::OP_POP_BACK;
        end
        default: cmd.op = cdq_pkg::OP_NONE;  // query and unused codes
      endcase
    end
  end

endmodule

FILE: rtl/cdq_dpath.sv
// Deque datapath: word store, head/tail pointers, count and result registers.
module cdq_dpath #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cdq_pkg::cmd_t                          cmd,
  output cdq_pkg::stat_t                         stat,
  input  logic        [cdq_pkg::FUNC_W-1:0]      func,
  input  logic signed [cdq_pkg::WORD_W-1:0]      push_word,
  output logic signed [cdq_pkg::WORD_W-1:0]      popped_word,
  output logic                                   pop_error,
  output logic                                   push_dropped,
  output logic        [cdq_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                                   is_empty,
  output logic signed [cdq_pkg::WORD_W-1:0]      front_word,
  output logic signed [cdq_pkg::WORD_W-1:0]      back_word
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int ExtW = CntW + cdq_pkg::COUNT_OUT_W;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];

  logic [cdq_pkg::FUNC_W-1:0] func_q;
  logic [cdq_pkg::WORD_W-1:0] word_q;
  logic [PtrW-1:0]            head;
  logic [PtrW-1:0]            tail;
  logic [CntW-1:0]            count;
  logic [cdq_pkg::WORD_W-1:0] front_q;
  logic [cdq_pkg::WORD_W-1:0] back_q;
  logic [cdq_pkg::WORD_W-1:0] popped_q;
  logic                       perr_q;
  logic                       drop_q;

  logic [PtrW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [ExtW-1:0] cnt_ext;

  // Circular pointer steps
  always_comb begin
    head_inc = (head == LastPtr) ? '0 : head + PtrW'(1);
    head_dec = (head == '0) ? LastPtr : head - PtrW'(1);
    tail_inc = (tail == LastPtr) ? '0 : tail + PtrW'(1);
    tail_dec = (tail == '0) ? LastPtr : tail - PtrW'(1);
  end

  // Request beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      word_q <= push_word;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      case (cmd.op)
        cdq_pkg::OP_PUSH_FRONT: begin
          head  <= head_dec;
          count <= count + CntW'(1);
        end
        cdq_pkg::OP_PUSH_BACK: begin
          tail  <= tail_inc;
          count <= count + CntW'(1);
        end
        cdq_pkg::OP_POP_FRONT: begin
          head  <= head_inc;
          count <= count - CntW'(1);
        end
        cdq_pkg::OP_POP_BACK: begin
          tail  <= tail_dec;
          count <= count - CntW'(1);
        end
        default: ;
      endcase
    end
  end

  // Word store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.op == cdq_pkg::OP_PUSH_FRONT) mem[head_dec] <= word_q;
    if (cmd.exec && cmd.op == cdq_pkg::OP_PUSH_BACK)  mem[tail]     <= word_q;
    if (cmd.read) begin
      front_q <= mem[head];
      back_q  <= mem[tail_dec];
    end
  end

  // Result flags and popped word; front/back regs hold the previous ends
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      perr_q <= cmd.perr;
      drop_q <= cmd.drop;
      case (cmd.op)
        cdq_pkg::OP_POP_FRONT: popped_q <= front_q;
        cdq_pkg::OP_POP_BACK:  popped_q <= back_q;
        default:               popped_q <= cmd.perr ? '1 : '0;
      endcase
    end
  end

  assign stat.full  = (count == FullCnt);
  assign stat.empty = (count == '0);
  assign stat.func  = func_q;

  assign cnt_ext      = ExtW'(count);
  assign entry_count  = cnt_ext[cdq_pkg::COUNT_OUT_W-1:0];
  assign is_empty     = (count == '0);
  assign popped_word  = popped_q;
  assign pop_error    = perr_q;
  assign push_dropped = drop_q;
  assign front_word   = is_empty ? '1 : front_q;
  assign back_word    = is_empty ? '1 : back_q;

endmodule
